FILE: rtl/core/gdo_pkg.sv
// Shared types, constants and a calendar function for the Gregorian date offset block.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package gdo_pkg;

   localparam int OFFSET_BITS_DEF = 16;
   localparam int YEAR_MAX_DEF    = 9999;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int IDX_W   = 2;
   localparam int CSR_W   = 14;

   localparam logic [IDX_W-1:0] REG_START_DAY   = 2'd0;
   localparam logic [IDX_W-1:0] REG_START_MONTH = 2'd1;
   localparam logic [IDX_W-1:0] REG_START_YEAR  = 2'd2;

   localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
   localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
   localparam int                 RESET_YEAR  = 2000;

   localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

   // Quotient by 100 as a multiply by a scaled reciprocal; exact for 14-bit years.
   localparam int          RECIP_W     = 13;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int          PROD_W      = YEAR_W + RECIP_W;
   localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

   typedef struct packed {
      logic load;
      logic leap_div;
      logic leap_eval;
      logic step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic settled;
      logic wrap;
      logic bound_hit;
   } status_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         FEBRUARY:                len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/core/gregorian_date_offset.sv
// Top level of the Gregorian date offset block: stream ports, controller and datapath.
// Depends on gdo_pkg, gdo_ctrl and gdo_dpath.
// For an accepted item the controller loads the working date, evaluates the leap flag and
// steps months, one per cycle in the month loop except where a year boundary is crossed;
// each crossing reloads the leap flag through a reciprocal divide by 100 in the leap states.
// One item is in work at a time; the next is accepted as soon as the result is registered.
// Synchronous active-high reset loads the date 2000-01-01 and empties the result register.
`timescale 1ns / 1ps

module gregorian_date_offset #(
   parameter int OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF,
   parameter int YEAR_MAX    = gdo_pkg::YEAR_MAX_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((OFFSET_BITS+7)/8)*8-1:0]  req_tdata,   // day_offset
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,   // out_day, out_month, out_year
   output logic [0:0]                        rsp_tuser,   // out_of_range
   input  logic                              csr_we,
   input  logic [gdo_pkg::IDX_W-1:0]         csr_index,
   input  logic [gdo_pkg::CSR_W-1:0]         csr_wdata
);

   gdo_pkg::cmd_type    cmd;
   gdo_pkg::status_type status;

   logic [gdo_pkg::DAY_W-1:0]   out_day;
   logic [gdo_pkg::MONTH_W-1:0] out_month;
   logic [gdo_pkg::YEAR_W-1:0]  out_year;
   logic                        out_of_range;

   gdo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gdo_dpath #(
      .OFFSET_BITS (OFFSET_BITS),
      .YEAR_MAX    (YEAR_MAX)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .day_offset   ($signed(req_tdata[OFFSET_BITS-1:0])),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .out_day      (out_day),
      .out_month    (out_month),
      .out_year     (out_year),
      .out_of_range (out_of_range)
   );

   assign rsp_tdata = {1'b0, out_year, out_month, out_day};
   assign rsp_tuser = out_of_range;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block took a new item while one was in work");

   a_valid_date: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[4:0] != 5'd0 && rsp_tdata[8:5] != 4'd0 &&
                      rsp_tdata[8:5] <= 4'd12))
      else $error("result carries an invalid day or month");

   a_year_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[22:9] <= gdo_pkg::YEAR_W'(YEAR_MAX)))
      else $error("result year beyond the upper bound");

   a_no_step_while_loading: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !(cmd.step || cmd.finish))
      else $error("load collided with a step or a commit");

endmodule

FILE: rtl/core/gdo_ctrl.sv
// Sequencer for the date offset block: leap evaluation, month stepping and result hand-off.
// Depends on gdo_pkg for the command and status structs.
`timescale 1ns / 1ps

module gdo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  gdo_pkg::status_type status,
   output gdo_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_LEAP1  = 5'b00010,
      ST_LEAP2  = 5'b00100,
      ST_STEP   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_LEAP1;
            end
         end
         ST_LEAP1: begin
            cmd.leap_div = 1'b1;
            state_in     = ST_LEAP2;
         end
         ST_LEAP2: begin
            cmd.leap_eval = 1'b1;
            state_in      = ST_STEP;
         end
         ST_STEP: begin
            cmd.step = 1'b1;
            if (status.settled || status.bound_hit) begin
               state_in = ST_FINISH;
            end else if (status.wrap) begin
               state_in = ST_LEAP1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/gdo_dpath.sv
// Datapath for the date offset block: current date, working date, leap flag and result register.
// Depends on gdo_pkg for widths, codes, the command structs and month lengths.
`timescale 1ns / 1ps

module gdo_dpath #(
   parameter int OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF,
   parameter int YEAR_MAX    = gdo_pkg::YEAR_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [OFFSET_BITS-1:0]       day_offset,
   input  logic                                csr_we,
   input  logic [gdo_pkg::IDX_W-1:0]           csr_index,
   input  logic [gdo_pkg::CSR_W-1:0]           csr_wdata,
   input  gdo_pkg::cmd_type                    cmd,
   output gdo_pkg::status_type                 status,
   output logic [gdo_pkg::DAY_W-1:0]           out_day,
   output logic [gdo_pkg::MONTH_W-1:0]         out_month,
   output logic [gdo_pkg::YEAR_W-1:0]          out_year,
   output logic                                out_of_range
);

   localparam int DW = OFFSET_BITS + 2;
   localparam int YW = gdo_pkg::YEAR_W;
   localparam int MW = gdo_pkg::MONTH_W;
   localparam int QW = gdo_pkg::QUOT_W;
   localparam logic [YW-1:0] YMAX = YW'(YEAR_MAX);
   localparam logic [YW-1:0] YRST = (gdo_pkg::RESET_YEAR > YEAR_MAX) ?
                                    YW'(YEAR_MAX) : YW'(gdo_pkg::RESET_YEAR);

   logic [gdo_pkg::DAY_W-1:0] cur_day_ff, cur_day_in;
   logic [MW-1:0]             cur_month_ff, cur_month_in;
   logic [YW-1:0]             cur_year_ff, cur_year_in;

   logic signed [DW-1:0]      d_ff, d_in;
   logic [MW-1:0]             m_ff, m_in;
   logic [YW-1:0]             y_ff, y_in;
   logic                      bad_ff, bad_in;
   logic [QW-1:0]             q_ff;
   logic                      leap_ff;

   logic [gdo_pkg::DAY_W-1:0]   rsp_day_ff;
   logic [MW-1:0]               rsp_month_ff;
   logic [YW-1:0]               rsp_year_ff;
   logic                        rsp_bad_ff;

   logic [gdo_pkg::PROD_W-1:0]  prod;
   logic [QW+6:0]               q_times_100;
   logic [gdo_pkg::DAY_W-1:0]   len_cur, len_prev;
   logic [MW-1:0]               prev_month;
   logic                        fwd, bwd;
   logic [gdo_pkg::DAY_W-1:0]   wr_day;
   logic [MW-1:0]               wr_month;
   logic [YW-1:0]               wr_year;

   assign prod        = gdo_pkg::PROD_W'(y_ff) * gdo_pkg::PROD_W'(gdo_pkg::RECIP_100);
   assign q_times_100 = ((QW+7)'(q_ff) << 6) + ((QW+7)'(q_ff) << 5) + ((QW+7)'(q_ff) << 2);

   assign prev_month = (m_ff == gdo_pkg::JANUARY) ? gdo_pkg::DECEMBER : m_ff - MW'(1);
   assign len_cur    = gdo_pkg::month_len(m_ff, leap_ff);
   assign len_prev   = gdo_pkg::month_len(prev_month, leap_ff);

   assign fwd = d_ff > $signed({{(DW-gdo_pkg::DAY_W){1'b0}}, len_cur});
   assign bwd = d_ff[DW-1] || (d_ff == '0);

   assign status.settled   = !fwd && !bwd;
   assign status.wrap      = (fwd && m_ff == gdo_pkg::DECEMBER) ||
                             (bwd && m_ff == gdo_pkg::JANUARY);
   assign status.bound_hit = (fwd && m_ff == gdo_pkg::DECEMBER && y_ff == YMAX) ||
                             (bwd && m_ff == gdo_pkg::JANUARY && y_ff == '0);

   always_comb begin
      wr_day = csr_wdata[gdo_pkg::DAY_W-1:0];
      if (wr_day == '0) begin
         wr_day = gdo_pkg::DAY_W'(1);
      end
      wr_month = csr_wdata[MW-1:0];
      if (wr_month == '0) begin
         wr_month = gdo_pkg::JANUARY;
      end else if (wr_month > gdo_pkg::DECEMBER) begin
         wr_month = gdo_pkg::DECEMBER;
      end
      wr_year = csr_wdata[YW-1:0];
      if (wr_year > YMAX) begin
         wr_year = YMAX;
      end
   end

   always_comb begin
      d_in   = d_ff;
      m_in   = m_ff;
      y_in   = y_ff;
      bad_in = bad_ff;
      if (cmd.load) begin
         d_in   = $signed({{(DW-gdo_pkg::DAY_W){1'b0}}, cur_day_ff}) + DW'(day_offset);
         m_in   = cur_month_ff;
         y_in   = cur_year_ff;
         bad_in = 1'b0;
      end else if (cmd.step) begin
         if (status.bound_hit) begin
            bad_in = 1'b1;
         end else if (fwd) begin
            d_in = d_ff - $signed({{(DW-gdo_pkg::DAY_W){1'b0}}, len_cur});
            if (m_ff == gdo_pkg::DECEMBER) begin
               m_in = gdo_pkg::JANUARY;
               y_in = y_ff + YW'(1);
            end else begin
               m_in = m_ff + MW'(1);
            end
         end else if (bwd) begin
            d_in = d_ff + $signed({{(DW-gdo_pkg::DAY_W){1'b0}}, len_prev});
            m_in = prev_month;
            if (m_ff == gdo_pkg::JANUARY) begin
               y_in = y_ff - YW'(1);
            end
         end
      end
   end

   always_comb begin
      cur_day_in   = cur_day_ff;
      cur_month_in = cur_month_ff;
      cur_year_in  = cur_year_ff;
      if (csr_we) begin
         case (csr_index)
            gdo_pkg::REG_START_DAY:   cur_day_in   = wr_day;
            gdo_pkg::REG_START_MONTH: cur_month_in = wr_month;
            gdo_pkg::REG_START_YEAR:  cur_year_in  = wr_year;
            default: begin
            end
         endcase
      end else if (cmd.finish && !bad_ff) begin
         cur_day_in   = d_ff[gdo_pkg::DAY_W-1:0];
         cur_month_in = m_ff;
         cur_year_in  = y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_day_ff   <= gdo_pkg::RESET_DAY;
         cur_month_ff <= gdo_pkg::RESET_MONTH;
         cur_year_ff  <= YRST;
      end else begin
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff   <= d_in;
      m_ff   <= m_in;
      y_ff   <= y_in;
      bad_ff <= bad_in;
      if (cmd.leap_div) begin
         q_ff <= prod[gdo_pkg::PROD_W-1:gdo_pkg::RECIP_SHIFT];
      end
      if (cmd.leap_eval) begin
         leap_ff <= (y_ff[1:0] == 2'b00) &&
                    ((q_times_100 != (QW+7)'(y_ff)) || (q_ff[1:0] == 2'b00));
      end
      if (cmd.finish) begin
         rsp_day_ff   <= bad_ff ? cur_day_ff   : d_ff[gdo_pkg::DAY_W-1:0];
         rsp_month_ff <= bad_ff ? cur_month_ff : m_ff;
         rsp_year_ff  <= bad_ff ? cur_year_ff  : y_ff;
         rsp_bad_ff   <= bad_ff;
      end
   end

   assign out_day      = rsp_day_ff;
   assign out_month    = rsp_month_ff;
   assign out_year     = rsp_year_ff;
   assign out_of_range = rsp_bad_ff;

endmodule

FILE: bench/gregorian_date_offset_tb.sv
// Self-checking bench for gregorian_date_offset: streams signed day offsets and checks each date.
// Uses gdo_pkg for register indexes and widths; predicts dates with its own calendar model.
`timescale 1ns / 1ps

module gregorian_date_offset_tb;

   localparam int YEAR_LIMIT = gdo_pkg::YEAR_MAX_DEF;
   localparam logic [gdo_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [gdo_pkg::DAY_W-1:0]   day;
      logic [gdo_pkg::MONTH_W-1:0] month;
      logic [gdo_pkg::YEAR_W-1:0]  year;
      logic                        out_of_range;
   } date_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [15:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [gdo_pkg::IDX_W-1:0] csr_index = '0;
   logic [gdo_pkg::CSR_W-1:0] csr_wdata = '0;

   logic [15:0] pending_offsets[$];
   date_result_type expected_dates[$];

   int cal_day = 1;
   int cal_month = 1;
   int cal_year = 2000;

   bit no_idle = 1'b0;
   int send_gap = 0;
   int stall_left = 0;
   int items_accepted = 0;
   int dates_checked = 0;
   int range_hits = 0;
   int settings_used = 0;
   int fail_count = 0;

   gregorian_date_offset DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit is_leap(input int y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int days_in_month(input int m, input int y);
      if (m == 4 || m == 6 || m == 9 || m == 11)
         return 30;
      if (m == int'(gdo_pkg::FEBRUARY))
         return is_leap(y) ? 29 : 28;
      return 31;
   endfunction

   function automatic date_result_type advance_date(input int d0, input int m0, input int y0,
                                                    input logic signed [15:0] off);
      date_result_type r;
      int d;
      int m;
      int y;
      bit bad;
      d = d0 + off;
      m = m0;
      y = y0;
      bad = 1'b0;
      while (!bad && d > days_in_month(m, y)) begin
         d -= days_in_month(m, y);
         m++;
         if (m > 12) begin
            m = 1;
            y++;
            if (y > YEAR_LIMIT)
               bad = 1'b1;
         end
      end
      while (!bad && d < 1) begin
         m--;
         if (m < 1) begin
            m = 12;
            y--;
         end
         if (y < 0)
            bad = 1'b1;
         else
            d += days_in_month(m, y);
      end
      if (bad) begin
         r.day = d0[gdo_pkg::DAY_W-1:0];
         r.month = m0[gdo_pkg::MONTH_W-1:0];
         r.year = y0[gdo_pkg::YEAR_W-1:0];
      end else begin
         r.day = d[gdo_pkg::DAY_W-1:0];
         r.month = m[gdo_pkg::MONTH_W-1:0];
         r.year = y[gdo_pkg::YEAR_W-1:0];
      end
      r.out_of_range = bad;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 15);
      return $urandom_range(30, 150);
   endfunction

   function automatic logic [15:0] pick_offset();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return 16'($urandom_range(0, 800)) - 16'd400;
      if (r < 70)
         return 16'($urandom_range(0, 10000)) - 16'd5000;
      return 16'($urandom_range(0, 65535));
   endfunction

   always @(posedge clock) begin : offset_driver
      date_result_type want;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         send_gap <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            want = advance_date(cal_day, cal_month, cal_year, $signed(req_tdata));
            if (!want.out_of_range) begin
               cal_day = want.day;
               cal_month = want.month;
               cal_year = want.year;
            end
            expected_dates.push_back(want);
            items_accepted++;
         end
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (pending_offsets.size() != 0) begin
               req_tdata <= pending_offsets.pop_front();
               req_tvalid <= 1'b1;
               send_gap <= pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : date_monitor
      date_result_type want;
      int g;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            dates_checked++;
            if (rsp_tuser[0])
               range_hits++;
            if (expected_dates.size() == 0) begin
               $error("unexpected date item: day %0d month %0d year %0d flag %0d",
                      rsp_tdata[4:0], rsp_tdata[8:5], rsp_tdata[22:9], rsp_tuser[0]);
               fail_count++;
            end else begin
               want = expected_dates.pop_front();
               if (rsp_tdata[4:0] !== want.day) begin
                  $error("out_day: expected %0d, got %0d", want.day, rsp_tdata[4:0]);
                  fail_count++;
               end
               if (rsp_tdata[8:5] !== want.month) begin
                  $error("out_month: expected %0d, got %0d", want.month, rsp_tdata[8:5]);
                  fail_count++;
               end
               if (rsp_tdata[22:9] !== want.year) begin
                  $error("out_year: expected %0d, got %0d", want.year, rsp_tdata[22:9]);
                  fail_count++;
               end
               if (rsp_tuser[0] !== want.out_of_range) begin
                  $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                         rsp_tuser[0]);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (rsp_tvalid && rsp_tready) begin
            g = pick_gap();
            stall_left <= g;
            rsp_tready <= (g == 0);
         end else if (!rsp_tvalid && $urandom_range(0, 9) == 0) begin
            g = pick_gap();
            stall_left <= g;
            rsp_tready <= (g == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pending_offsets.size() != 0 || req_tvalid || expected_dates.size() != 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [gdo_pkg::IDX_W-1:0] idx,
                            input logic [gdo_pkg::CSR_W-1:0] val);
      int v;
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         gdo_pkg::REG_START_DAY: begin
            v = val[gdo_pkg::DAY_W-1:0];
            cal_day = (v == 0) ? 1 : v;
         end
         gdo_pkg::REG_START_MONTH: begin
            v = val[gdo_pkg::MONTH_W-1:0];
            cal_month = (v == 0) ? 1 : ((v > 12) ? 12 : v);
         end
         gdo_pkg::REG_START_YEAR: begin
            v = val[gdo_pkg::YEAR_W-1:0];
            cal_year = (v > YEAR_LIMIT) ? YEAR_LIMIT : v;
         end
         default: ;
      endcase
   endtask

   task automatic set_date(input int d, input int m, input int y);
      wait_idle();
      write_reg(gdo_pkg::REG_START_DAY, gdo_pkg::CSR_W'(d));
      write_reg(gdo_pkg::REG_START_MONTH, gdo_pkg::CSR_W'(m));
      write_reg(gdo_pkg::REG_START_YEAR, gdo_pkg::CSR_W'(y));
      settings_used++;
   endtask

   initial begin : stimulus
      int kind;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      pending_offsets.push_back(16'd0);
      pending_offsets.push_back(16'd1);
      pending_offsets.push_back(16'hFFFF);
      pending_offsets.push_back(16'h7FFF);
      pending_offsets.push_back(16'h8000);
      pending_offsets.push_back(16'h5555);
      pending_offsets.push_back(16'hAAAA);

      set_date(28, 2, 1900);
      pending_offsets.push_back(16'd1);
      set_date(28, 2, 2000);
      pending_offsets.push_back(16'd1);
      set_date(31, 2, 2001);
      pending_offsets.push_back(16'd0);
      set_date(0, 0, 2001);
      pending_offsets.push_back(16'd0);
      set_date(31, 15, 16383);
      pending_offsets.push_back(16'd1);
      pending_offsets.push_back(-16'sd365);
      set_date(1, 1, 0);
      pending_offsets.push_back(16'hFFFF);
      pending_offsets.push_back(16'd59);

      wait_idle();
      write_reg(gdo_pkg::REG_START_MONTH, gdo_pkg::CSR_W'(13));
      pending_offsets.push_back(16'd0);
      wait_idle();
      write_reg(REG_UNUSED, 14'h3FFF);
      pending_offsets.push_back(16'd0);

      set_date(31, 12, 9999);
      pending_offsets.push_back(16'h8000);
      pending_offsets.push_back(16'h7FFF);
      set_date(1, 1, 0);
      pending_offsets.push_back(16'h7FFF);

      for (int phase = 0; phase < 18; phase++) begin
         kind = $urandom_range(0, 5);
         case (kind)
            0: set_date($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 16383));
            1: set_date($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(9900, 9999));
            2: set_date($urandom_range(1, 31), $urandom_range(1, 12), $urandom_range(0, 99));
            default: set_date($urandom_range(1, 31), $urandom_range(1, 12),
                              $urandom_range(0, 9999));
         endcase
         no_idle = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < 30; n++)
            pending_offsets.push_back(pick_offset());
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Checked %0d dates for %0d offsets over %0d start dates; %0d left the year range.",
               dates_checked, items_accepted, settings_used, range_hits);
      if (fail_count == 0 && expected_dates.size() == 0) begin
         $display("[gregorian_date_offset] OK");
      end else begin
         $display("[gregorian_date_offset] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #15_000_000;
      $display("Run did not finish in time; %0d dates still outstanding.", expected_dates.size());
      $display("[gregorian_date_offset] ERROR");
      $finish;
   end

endmodule
